### design/pobe_pkg.sv
// pobe_pkg: shared types and constants for the plotter operand byte encoder
// no dependencies; imported by the front end, queue, back end and top level

package pobe_pkg;

    // most bytes that one operand can produce
    localparam int MAX_BYTES = 6;

    typedef logic [6:0] t_byte;
    typedef logic [2:0] t_len;

    // operand formats
    typedef enum logic [1:0] {
        REQ_SINGLE = 2'd0,
        REQ_NUMBER = 2'd1,
        REQ_PAIR   = 2'd2,
        REQ_REL    = 2'd3
    } t_req;

    // one encoded operand, byte 0 goes out first
    typedef struct packed {
        t_byte [MAX_BYTES-1:0] bytes;
        t_len                  len;
    } t_entry;

    // first-byte prefix, complement bit and relative-pair tags
    localparam t_byte PFX_FIRST = 7'h60;
    localparam t_byte COMP_BIT  = 7'h40;
    localparam t_byte TAG_X     = 7'h40;
    localparam t_byte TAG_Y     = 7'h20;

    // saturation limits
    localparam logic [13:0]        MAG_MAX = 14'd16383;
    localparam logic signed [15:0] REL_HI  = 16'sd16383;
    localparam logic signed [15:0] REL_LO  = -16'sd16384;

endpackage

### design/pobe_front.sv
// pobe_front: input handshake and operand encoder for all four formats
// depends on pobe_pkg; writes one finished entry per transfer into the queue

module pobe_front (
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_req_type,
    input  logic signed [15:0] i_value_a,
    input  logic signed [15:0] i_value_b,
    input  logic              i_q_full,
    output logic              o_push,
    output pobe_pkg::t_entry  o_entry
);
    import pobe_pkg::*;

    typedef struct packed {
        t_byte [2:0] c;
        logic [1:0]  n;
    } t_rel;

    // complement bit set when bit 5 of the chunk is clear
    function automatic t_byte comp6(input logic [5:0] c);
        return {~c[5], c};
    endfunction

    function automatic logic [13:0] sat_mag(input logic signed [15:0] v);
        logic [15:0] m;
        m = v[15] ? 16'(-v) : 16'(v);
        return (m > 16'(MAG_MAX)) ? MAG_MAX : m[13:0];
    endfunction

    function automatic logic signed [14:0] sat_rel(input logic signed [15:0] v);
        logic signed [15:0] s;
        priority if (v > REL_HI) begin
            s = REL_HI;
        end else if (v < REL_LO) begin
            s = REL_LO;
        end else begin
            s = v;
        end
        return s[14:0];
    endfunction

    // 5-bit two's complement chunks, most significant first
    function automatic t_rel rel_chunks(input logic signed [14:0] v, input t_byte tag);
        t_rel r;
        r = '0;
        priority if (v > 15'sd511 || v < -15'sd512) begin
            r.c[0] = {2'b00, v[14:10]} | tag;
            r.c[1] = {2'b00, v[9:5]} | tag;
            r.c[2] = {2'b00, v[4:0]} | tag;
            r.n    = 2'd3;
        end else if (v > 15'sd15 || v < -15'sd16) begin
            r.c[0] = {2'b00, v[9:5]} | tag;
            r.c[1] = {2'b00, v[4:0]} | tag;
            r.n    = 2'd2;
        end else begin
            r.c[0] = {2'b00, v[4:0]} | tag;
            r.n    = 2'd1;
        end
        return r;
    endfunction

    logic [13:0] w_x;
    logic [13:0] w_y;
    logic [13:0] w_m;
    t_rel        w_rx;
    t_rel        w_ry;

    assign w_x  = sat_mag(i_value_a);
    assign w_y  = sat_mag(i_value_b);
    assign w_m  = (w_x > w_y) ? w_x : w_y;
    assign w_rx = rel_chunks(sat_rel(i_value_a), TAG_X);
    assign w_ry = rel_chunks(sat_rel(i_value_b), TAG_Y);

    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        logic [2:0] k;
        k = '0;
        o_entry = '0;
        unique case (t_req'(i_req_type))
            REQ_SINGLE: begin
                o_entry.bytes[0] = i_value_a[5] ? i_value_a[6:0]
                                                : ({1'b0, i_value_a[5:0]} | COMP_BIT);
                o_entry.len = 3'd1;
            end
            REQ_NUMBER: begin
                priority if (w_x >= 14'd1024) begin
                    o_entry.bytes[0] = PFX_FIRST | 7'(w_x[13:12]);
                    o_entry.bytes[1] = comp6(w_x[11:6]);
                    o_entry.bytes[2] = comp6(w_x[5:0]);
                    o_entry.len = 3'd3;
                end else if (w_x >= 14'd16) begin
                    o_entry.bytes[0] = PFX_FIRST | 7'(w_x[9:6]);
                    o_entry.bytes[1] = comp6(w_x[5:0]);
                    o_entry.len = 3'd2;
                end else begin
                    o_entry.bytes[0] = PFX_FIRST | 7'(w_x[3:0]);
                    o_entry.len = 3'd1;
                end
            end
            REQ_PAIR: begin
                priority if (w_m >= 14'd2048) begin
                    o_entry.bytes[0] = PFX_FIRST | 7'(w_x[13:10]);
                    o_entry.bytes[1] = comp6(w_x[9:4]);
                    o_entry.bytes[2] = comp6({w_x[3:0], w_y[13:12]});
                    o_entry.bytes[3] = comp6(w_y[11:6]);
                    o_entry.bytes[4] = comp6(w_y[5:0]);
                    o_entry.len = 3'd5;
                end else if (w_m >= 14'd256) begin
                    o_entry.bytes[0] = PFX_FIRST | 7'(w_x[10:7]);
                    o_entry.bytes[1] = comp6(w_x[6:1]);
                    o_entry.bytes[2] = comp6({w_x[0], w_y[10:6]});
                    o_entry.bytes[3] = comp6(w_y[5:0]);
                    o_entry.len = 3'd4;
                end else if (w_m >= 14'd32) begin
                    o_entry.bytes[0] = PFX_FIRST | 7'(w_x[7:4]);
                    o_entry.bytes[1] = comp6({w_x[3:0], w_y[7:6]});
                    o_entry.bytes[2] = comp6(w_y[5:0]);
                    o_entry.len = 3'd3;
                end else if (w_m >= 14'd4) begin
                    o_entry.bytes[0] = PFX_FIRST | 7'(w_x[4:1]);
                    o_entry.bytes[1] = comp6({w_x[0], w_y[4:0]});
                    o_entry.len = 3'd2;
                end else begin
                    o_entry.bytes[0] = PFX_FIRST | 7'({w_x[1:0], w_y[1:0]});
                    o_entry.len = 3'd1;
                end
            end
            REQ_REL: begin
                // x chunks first, y chunks follow right after them
                for (int i = 0; i < MAX_BYTES; i++) begin
                    k = 3'(i) - {1'b0, w_rx.n};
                    if (3'(i) < {1'b0, w_rx.n}) begin
                        o_entry.bytes[3'(i)] = w_rx.c[2'(i)];
                    end else if (k < {1'b0, w_ry.n}) begin
                        o_entry.bytes[3'(i)] = w_ry.c[k[1:0]];
                    end
                end
                o_entry.len = {1'b0, w_rx.n} + {1'b0, w_ry.n};
            end
            default: begin
                o_entry = '0;
            end
        endcase
    end

endmodule

### design/pobe_queue.sv
// pobe_queue: short fifo of encoded operands between front and back end
// depends on pobe_pkg for the entry type

module pobe_queue #(
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pobe_pkg::t_entry i_entry,
    input  logic             i_pop,
    output pobe_pkg::t_entry o_entry,
    output logic             o_valid,
    output logic             o_full
);
    import pobe_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry          r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic [PW-1:0]   n_wr_ptr;
    logic [PW-1:0]   n_rd_ptr;
    logic [CW-1:0]   n_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_entry = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

### design/pobe_back.sv
// pobe_back: byte serializer with registered output channel
// depends on pobe_pkg; pops an operand, sends one byte per cycle unless stalled

module pobe_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  pobe_pkg::t_entry    i_entry,
    output logic                o_pop,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output pobe_pkg::t_byte     o_out_byte,
    output logic                o_last_byte
);
    import pobe_pkg::*;

    t_entry r_cur;
    t_len   r_idx;
    logic   r_busy;
    logic   r_out_valid;
    t_byte  r_out_byte;
    logic   r_last;

    t_entry n_cur;
    t_len   n_idx;
    logic   n_busy;
    logic   n_out_valid;
    t_byte  n_out_byte;
    logic   n_last;

    logic   w_load;

    // output register can take a new byte
    assign w_load = !r_out_valid || !i_out_stall;

    always_comb begin
        n_cur       = r_cur;
        n_idx       = r_idx;
        n_busy      = r_busy;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_last      = r_last;
        o_pop       = 1'b0;
        if (w_load) begin
            priority if (r_busy) begin
                n_out_valid = 1'b1;
                n_out_byte  = r_cur.bytes[r_idx];
                n_last      = (r_idx == r_cur.len - 3'd1);
                n_idx       = r_idx + 3'd1;
                n_busy      = !n_last;
            end else if (i_q_valid) begin
                o_pop       = 1'b1;
                n_cur       = i_entry;
                n_out_valid = 1'b1;
                n_out_byte  = i_entry.bytes[0];
                n_last      = (i_entry.len == 3'd1);
                n_idx       = 3'd1;
                n_busy      = !n_last;
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_idx      <= n_idx;
        r_out_byte <= n_out_byte;
        r_last     <= n_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_last_byte = r_last;

endmodule

### design/plotter_operand_byte_encoder.sv
// Plotter operand byte encoder, top level. One input transfer carries one operand request
// (single byte, number, unsigned pair or signed relative pair); the block answers with
// the plotter's 7-bit command bytes for it, most significant chunk first, with
// o_last_byte set on the final byte. The front end encodes the whole operand in the
// cycle it is accepted and writes it to a QUEUE_DEPTH-entry queue; the back end pops it
// and sends one byte per cycle, while the output is not stalled, through a registered
// output. An operand holds 1 to 6 bytes, by format and magnitude, and holds the output
// channel until its last byte is sent; the byte serializer in the back end pops the
// next operand only after it has loaded that last byte. When the block is empty the
// first byte passes through the queue and the output register before it is valid.
// Reset is synchronous, active low, and only clears control state.
// depends on pobe_pkg, pobe_front, pobe_queue and pobe_back

module plotter_operand_byte_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_req_type,
    input  logic signed [15:0] i_value_a,
    input  logic signed [15:0] i_value_b,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [6:0]         o_out_byte,
    output logic               o_last_byte
);
    import pobe_pkg::*;

    // front end to queue
    logic   w_push;
    t_entry w_push_entry;
    logic   w_q_full;

    // queue to back end
    logic   w_q_valid;
    t_entry w_q_entry;
    logic   w_pop;

    // encode on the input transfer, stall only while the queue is full
    pobe_front u_front (
        .i_valid    (i_in_valid),
        .o_stall    (o_in_stall),
        .i_req_type (i_req_type),
        .i_value_a  (i_value_a),
        .i_value_b  (i_value_b),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_entry    (w_push_entry)
    );

    // decouples the encoder from output back-pressure
    pobe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_entry (w_q_entry),
        .o_valid (w_q_valid),
        .o_full  (w_q_full)
    );

    // one byte per output transfer, next operand follows without a gap
    pobe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_entry     (w_q_entry),
        .o_pop       (w_pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_byte  (o_out_byte),
        .o_last_byte (o_last_byte)
    );

`ifndef NO_ASSERTIONS
    // never write into a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_full)
        else $error("push into full operand queue");

    // back end pops only a queued operand
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("pop from empty operand queue");

    // every encoded operand holds one to six bytes
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (w_push_entry.len != 3'd0 && w_push_entry.len <= 3'(MAX_BYTES)))
        else $error("encoded operand length out of range");

    // an operand leaves the queue only after the previous one sent its last byte
    a_pop_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop && o_out_valid |-> o_last_byte)
        else $error("operand popped before previous one finished");
`endif

endmodule
